// File: rtl/core/lrr_pkg.sv
// shared constants for the lehmer random-in-range block
`default_nettype none

package lrr_pkg;

    // generator word width and modulus 2^31 - 1
    localparam int unsigned WordW = 31;
    localparam logic [WordW-1:0] LCG_MOD = 31'h7FFF_FFFF;

    // minimal standard multiplier, scanned one bit per cycle msb first
    localparam int unsigned MultW = 15;
    localparam logic [MultW-1:0] LCG_MULT = 15'd16807;

    // step counter widths
    localparam int unsigned MulCntW = 4;
    localparam int unsigned DivCntW = 5;

endpackage

`default_nettype wire

// File: rtl/core/lrr_mulmod.sv
// bit-serial multiply of the generator word by 16807 modulo 2^31 - 1
`default_nettype none

module lrr_mulmod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lrr_pkg::WordW-1:0] operand,
    output logic                           done,
    output logic [lrr_pkg::WordW-1:0]      product
);
    import lrr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MulCntW-1:0]   cnt_reg, cnt_next;
    logic [WordW-1:0]     acc_reg, acc_next;
    logic [WordW-1:0]     mcand_reg, mcand_next;

    logic [WordW-1:0]     acc_rot;
    logic [WordW:0]       sum;
    logic [WordW-1:0]     folded;
    logic                 mult_bit;

    // doubling mod 2^31-1 is a rotate, then add the multiplicand and fold the carry back
    always_comb
    begin
        mult_bit = LCG_MULT[cnt_reg];
        acc_rot  = {acc_reg[WordW-2:0], acc_reg[WordW-1]};
        sum      = {1'b0, acc_rot} + (mult_bit ? {1'b0, mcand_reg} : {1'b0, {WordW{1'b0}}});
        folded   = sum[WordW-1:0] + {{(WordW-1){1'b0}}, sum[WordW]};
    end

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = MulCntW'(MultW - 1);
            acc_next   = '0;
            mcand_next = operand;
        end
        else if (busy_reg)
        begin
            acc_next = folded;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    // the modulus itself is the second form of zero
    assign done    = done_reg;
    assign product = (acc_reg == LCG_MOD) ? '0 : acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/lrr_divmod.sv
// restoring remainder unit, one dividend bit per cycle
`default_nettype none

module lrr_divmod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lrr_pkg::WordW-1:0] dividend,
    input  wire logic [lrr_pkg::WordW-1:0] divisor,
    output logic                           done,
    output logic [lrr_pkg::WordW-1:0]      remainder
);
    import lrr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DivCntW-1:0]   cnt_reg, cnt_next;
    logic [WordW-1:0]     dvd_reg, dvd_next;
    logic [WordW-1:0]     dvs_reg, dvs_next;
    logic [WordW-1:0]     rem_reg, rem_next;

    logic [WordW:0]       shifted;
    logic [WordW+1:0]     diff;

    // shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[WordW-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DivCntW'(WordW - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WordW-2:0], 1'b0};
            rem_next = diff[WordW+1] ? shifted[WordW-1:0] : diff[WordW-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/lehmer_random_in_range_top.sv
// top level: minimal standard lehmer generator with range reduction
`default_nettype none

// Each accepted input word carries a bound n and yields one output word holding the
// next minimal standard generator value (state * 16807 mod 2^31-1) reduced modulo n,
// or zero with range_error set when n is zero; the state advances either way and
// starts at 1 after reset. One word at a time is in work: the multiply scans the 15
// multiplier bits, one per cycle, and the remainder unit takes one dividend bit per
// cycle, 31 in all, a step skipped for a zero bound. The next word is accepted as
// soon as the result sits in the output register, even while that register is still
// stalled.
module lehmer_random_in_range_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [lrr_pkg::WordW-1:0] range_bound,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [lrr_pkg::WordW-1:0]      random_value,
    output logic                           range_error
);
    import lrr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [WordW-1:0] gen_reg;
    logic [WordW-1:0] bound_reg;
    logic [WordW-1:0] res_value_reg;
    logic             res_err_reg;
    logic             out_valid_reg;
    logic [WordW-1:0] out_value_reg;
    logic             out_err_reg;

    logic             mul_start;
    logic             mul_done;
    logic [WordW-1:0] mul_operand;
    logic [WordW-1:0] mul_product;
    logic             div_start;
    logic             div_done;
    logic [WordW-1:0] div_rem;
    logic             out_free;

    // a zero state is forced to 1 before the step
    assign mul_operand = (gen_reg == '0) ? {{(WordW-1){1'b0}}, 1'b1} : gen_reg;
    assign mul_start   = (state_reg == ST_IDLE) && in_valid;
    assign div_start   = (state_reg == ST_MUL) && mul_done && (bound_reg != '0);
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != ST_IDLE);

    lrr_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    lrr_divmod u_divmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mul_product),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // sequencer, generator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= {{(WordW-1){1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a word leaving while the next one loads is handled in ST_DONE
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        gen_reg <= mul_product;
                        if (bound_reg == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            bound_reg <= range_bound;
        end
        if ((state_reg == ST_MUL) && mul_done && (bound_reg == '0))
        begin
            res_value_reg <= '0;
            res_err_reg   <= 1'b1;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            res_value_reg <= div_rem;
            res_err_reg   <= 1'b0;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_value_reg <= res_value_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;
    assign range_error  = out_err_reg;

endmodule

`default_nettype wire
